// ----- src/tfrb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tfrb_pkg;

  localparam int unsigned DefaultDepth = 8;
  localparam int unsigned StampW       = 32;
  localparam int unsigned DataW        = 32;
  localparam int unsigned SkipW        = 32;
  localparam int unsigned FillW        = 9;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_GET = 1'b1;

  typedef enum logic {
    CMD_ADD = 1'b0,
    CMD_GET = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    logic              op;
    logic [StampW-1:0] stamp;
    logic [DataW-1:0]  payload;
  } in_word_t;

  typedef struct packed {
    logic              ok;
    logic [DataW-1:0]  read_data;
    logic [StampW-1:0] read_stamp;
    logic [SkipW-1:0]  skip_total;
    logic [FillW-1:0]  fill_count;
  } out_word_t;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [StampW-1:0] stamp;
    logic [DataW-1:0]  payload;
  } cmd_t;

endpackage

`default_nettype wire

// ----- src/tfrb_cmd_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tfrb_cmd_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  output logic                   full_o,
  input  wire tfrb_pkg::in_word_t in_word_i,
  output logic                   cmd_valid_o,
  output tfrb_pkg::cmd_t         cmd_o,
  input  wire logic              cmd_take_i
);
  import tfrb_pkg::*;

  cmd_t       q_mem [2];
  cmd_t       cmd_in;
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       wr_en, rd_en;

  always_comb begin
    cmd_in.kind    = (in_word_i.op == OP_GET) ? CMD_GET : CMD_ADD;
    cmd_in.stamp   = in_word_i.stamp;
    cmd_in.payload = in_word_i.payload;
  end

  assign full_o      = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem[rd_ptr_q];
  assign wr_en       = push_i && !full_o;
  assign rd_en       = cmd_take_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = wr_en ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = rd_en ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 2'd1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      q_mem[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

// ----- src/tfrb_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tfrb_engine #(
  parameter int unsigned DEPTH = tfrb_pkg::DefaultDepth
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cmd_valid_i,
  input  wire tfrb_pkg::cmd_t  cmd_i,
  output logic                 cmd_take_o,
  input  wire logic            res_pop_i,
  output logic                 res_valid_o,
  output tfrb_pkg::out_word_t  res_o
);
  import tfrb_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic [StampW-1:0] stamp_mem [DEPTH];
  logic [DataW-1:0]  data_mem  [DEPTH];

  logic              state_q, state_d;
  logic [DEPTH-1:0]  cons_q, cons_d;
  logic [AW-1:0]     wpos_q, wpos_d;
  logic [CW-1:0]     avail_q, avail_d;
  logic [SkipW-1:0]  skip_q, skip_d;
  logic [StampW-1:0] last_q, last_d;
  cmd_t              cmd_q;
  logic [AW-1:0]     iss_addr_q, iss_addr_d;
  logic [CW-1:0]     iss_cnt_q, iss_cnt_d;
  logic [CW-1:0]     ev_cnt_q, ev_cnt_d;
  logic              have_q, have_d;
  logic [StampW-1:0] best_q, best_d;
  logic [AW-1:0]     tgt_q, tgt_d;
  logic              rd_vld_q;
  logic [AW-1:0]     rd_addr_q;
  logic [StampW-1:0] rd_stamp_q;
  logic [DataW-1:0]  rd_data_q;
  logic              rd_cons_q;
  out_word_t         res_q, res_d;
  logic              res_vld_q, res_vld_d;

  logic              slot_free, start, issue, ev, ev_last;
  logic              take, hit;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [StampW-1:0] mem_wstamp;
  logic [DataW-1:0]  mem_wdata;
  logic [AW-1:0]     fin_addr;

  assign slot_free   = !res_vld_q || res_pop_i;
  assign start       = (state_q == S_IDLE) && cmd_valid_i && slot_free;
  assign cmd_take_o  = start;
  assign issue       = (state_q == S_SCAN) && (iss_cnt_q != CW'(DEPTH));
  assign ev          = (state_q == S_SCAN) && rd_vld_q;
  assign ev_last     = ev && (ev_cnt_q == CW'(DEPTH - 1));
  assign take        = !rd_cons_q && (!have_q || (best_q < rd_stamp_q));
  assign hit         = !rd_cons_q && (last_q <= rd_stamp_q);
  assign res_o       = res_q;
  assign res_valid_o = res_vld_q;

  always_comb begin
    state_d    = state_q;
    cons_d     = cons_q;
    wpos_d     = wpos_q;
    avail_d    = avail_q;
    skip_d     = skip_q;
    last_d     = last_q;
    iss_addr_d = iss_addr_q;
    iss_cnt_d  = iss_cnt_q;
    ev_cnt_d   = ev_cnt_q;
    have_d     = have_q;
    best_d     = best_q;
    tgt_d      = tgt_q;
    res_d      = res_q;
    res_vld_d  = res_vld_q && !res_pop_i;
    mem_we     = 1'b0;
    mem_waddr  = wpos_q;
    mem_wstamp = cmd_i.stamp;
    mem_wdata  = cmd_i.payload;
    fin_addr   = wpos_q;

    if (issue) begin
      iss_addr_d = (iss_addr_q == AW'(DEPTH - 1)) ? '0 : iss_addr_q + 1'b1;
      iss_cnt_d  = iss_cnt_q + 1'b1;
    end

    if (start) begin
      res_d.read_data  = '0;
      res_d.read_stamp = '0;
      if (cmd_i.kind == CMD_ADD && cons_q[wpos_q]) begin
        // free slot at the write position
        mem_we            = 1'b1;
        cons_d[wpos_q]    = 1'b0;
        wpos_d            = (wpos_q == AW'(DEPTH - 1)) ? '0 : wpos_q + 1'b1;
        avail_d           = (avail_q == CW'(DEPTH)) ? avail_q : avail_q + 1'b1;
        res_d.ok          = 1'b1;
        res_d.skip_total  = skip_q;
        res_d.fill_count  = FillW'(avail_d);
        res_vld_d         = 1'b1;
      end else if (cmd_i.kind == CMD_GET && avail_q == '0) begin
        res_d.ok          = 1'b0;
        res_d.skip_total  = skip_q;
        res_d.fill_count  = FillW'(avail_q);
        res_vld_d         = 1'b1;
      end else begin
        state_d    = S_SCAN;
        iss_addr_d = wpos_q;
        iss_cnt_d  = '0;
        ev_cnt_d   = '0;
        have_d     = 1'b0;
      end
    end

    if (ev) begin
      ev_cnt_d = ev_cnt_q + 1'b1;
      if (cmd_q.kind == CMD_ADD) begin
        if (take) begin
          have_d = 1'b1;
          best_d = rd_stamp_q;
          tgt_d  = rd_addr_q;
        end
        if (ev_last) begin
          // overwrite the newest unread slot
          fin_addr          = take ? rd_addr_q : tgt_q;
          mem_we            = 1'b1;
          mem_waddr         = fin_addr;
          mem_wstamp        = cmd_q.stamp;
          mem_wdata         = cmd_q.payload;
          cons_d[fin_addr]  = 1'b0;
          wpos_d            = (fin_addr == AW'(DEPTH - 1)) ? '0 : fin_addr + 1'b1;
          avail_d           = (avail_q == CW'(DEPTH)) ? avail_q : avail_q + 1'b1;
          if (fin_addr != wpos_q && skip_q != '1) begin
            skip_d = skip_q + 1'b1;
          end
          res_d.ok          = 1'b0;
          res_d.read_data   = '0;
          res_d.read_stamp  = '0;
          res_d.skip_total  = skip_d;
          res_d.fill_count  = FillW'(avail_d);
          res_vld_d         = 1'b1;
          state_d           = S_IDLE;
        end
      end else if (hit) begin
        cons_d[rd_addr_q] = 1'b1;
        avail_d           = avail_q - 1'b1;
        last_d            = rd_stamp_q;
        res_d.ok          = 1'b1;
        res_d.read_data   = rd_data_q;
        res_d.read_stamp  = rd_stamp_q;
        res_d.skip_total  = skip_q;
        res_d.fill_count  = FillW'(avail_d);
        res_vld_d         = 1'b1;
        state_d           = S_IDLE;
      end else if (ev_last) begin
        res_d.ok          = 1'b0;
        res_d.read_data   = '0;
        res_d.read_stamp  = '0;
        res_d.skip_total  = skip_q;
        res_d.fill_count  = FillW'(avail_q);
        res_vld_d         = 1'b1;
        state_d           = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cons_q     <= '1;
      wpos_q     <= '0;
      avail_q    <= '0;
      skip_q     <= '0;
      last_q     <= '0;
      iss_addr_q <= '0;
      iss_cnt_q  <= '0;
      ev_cnt_q   <= '0;
      have_q     <= 1'b0;
      rd_vld_q   <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cons_q     <= cons_d;
      wpos_q     <= wpos_d;
      avail_q    <= avail_d;
      skip_q     <= skip_d;
      last_q     <= last_d;
      iss_addr_q <= iss_addr_d;
      iss_cnt_q  <= iss_cnt_d;
      ev_cnt_q   <= ev_cnt_d;
      have_q     <= have_d;
      rd_vld_q   <= issue;
      res_vld_q  <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      cmd_q <= cmd_i;
    end
    best_q <= best_d;
    tgt_q  <= tgt_d;
    res_q  <= res_d;
    if (issue) begin
      rd_addr_q  <= iss_addr_q;
      rd_stamp_q <= stamp_mem[iss_addr_q];
      rd_data_q  <= data_mem[iss_addr_q];
      rd_cons_q  <= cons_q[iss_addr_q];
    end
    if (mem_we) begin
      stamp_mem[mem_waddr] <= mem_wstamp;
      data_mem[mem_waddr]  <= mem_wdata;
    end
  end

endmodule

`default_nettype wire

// ----- src/timestamped_frame_ring_buffer_unit.sv -----
// An add into a free slot or a get on an empty ring is answered without a scan of the slots.
// Any other add scans all DEPTH slots through one memory read port.
// Any other get stops at its first eligible slot, or after all DEPTH slots if none is eligible.
// Throughput: one word per cycle on the fast cases while results are popped; no command is taken during a scan.
// A 2-word command queue and a result register decouple both sides.
// Reset: all slots marked consumed, counters and position cleared; slot memories not cleared.
`timescale 1ns / 1ps
`default_nettype none

module timestamped_frame_ring_buffer_unit #(
  parameter int unsigned DEPTH = tfrb_pkg::DefaultDepth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire tfrb_pkg::in_word_t in_word_i,
  output logic                    empty,
  input  wire logic               pop,
  output tfrb_pkg::out_word_t     res_word_o
);
  import tfrb_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_take;
  logic res_valid;

  tfrb_cmd_queue u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .in_word_i   (in_word_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  tfrb_engine #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .res_pop_i   (pop),
    .res_valid_o (res_valid),
    .res_o       (res_word_o)
  );

  assign empty = !res_valid;

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

class frame_ring_checker;
  logic [31:0]         slot_data     [tfrb_pkg::DefaultDepth];
  logic [31:0]         slot_stamp    [tfrb_pkg::DefaultDepth];
  bit                  slot_consumed [tfrb_pkg::DefaultDepth];
  int unsigned         wr_pos;
  int unsigned         avail;
  logic [31:0]         skips;
  logic [31:0]         last_stamp;
  tfrb_pkg::out_word_t expected_q[$];
  int unsigned         errors;

  function new();
    for (int i = 0; i < tfrb_pkg::DefaultDepth; i++) begin
      slot_data[i]     = '0;
      slot_stamp[i]    = '0;
      slot_consumed[i] = 1'b1;
    end
    wr_pos     = 0;
    avail      = 0;
    skips      = '0;
    last_stamp = '0;
    errors     = 0;
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  // accepted input word: advance the ring and queue the word it should produce
  function void note_word(tfrb_pkg::in_word_t w);
    tfrb_pkg::out_word_t want;
    int unsigned         pos;
    int unsigned         target;
    int unsigned         k;
    logic [31:0]         newest;
    want = '0;
    pos  = wr_pos;
    if (w.op == tfrb_pkg::OP_ADD) begin
      want.ok = 1'b1;
      if (!slot_consumed[pos]) begin
        // overwrite of an unread slot: redirect to the strictly newest unread one
        newest = slot_stamp[pos];
        target = pos;
        for (int i = 1; i < tfrb_pkg::DefaultDepth; i++) begin
          k = (pos + i) % tfrb_pkg::DefaultDepth;
          if (!slot_consumed[k] && newest < slot_stamp[k]) begin
            newest = slot_stamp[k];
            target = k;
          end
        end
        if (target != pos && skips != 32'hFFFF_FFFF) skips++;
        pos     = target;
        want.ok = 1'b0;
      end
      slot_data[pos]     = w.payload;
      slot_stamp[pos]    = w.stamp;
      slot_consumed[pos] = 1'b0;
      wr_pos = (pos + 1) % tfrb_pkg::DefaultDepth;
      if (avail < tfrb_pkg::DefaultDepth) avail++;
    end else if (avail != 0) begin
      for (int i = 0; i < tfrb_pkg::DefaultDepth; i++) begin
        k = (pos + i) % tfrb_pkg::DefaultDepth;
        if (!slot_consumed[k] && last_stamp <= slot_stamp[k]) begin
          slot_consumed[k] = 1'b1;
          want.ok          = 1'b1;
          want.read_data   = slot_data[k];
          want.read_stamp  = slot_stamp[k];
          last_stamp       = slot_stamp[k];
          avail--;
          break;
        end
      end
    end
    want.skip_total = skips;
    want.fill_count = avail[tfrb_pkg::FillW-1:0];
    expected_q.push_back(want);
  endfunction

  function void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    end
  endfunction

  function void check_word(tfrb_pkg::out_word_t got);
    tfrb_pkg::out_word_t want;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: result word with none expected, expected nothing, actual %p",
               $time, got);
      return;
    end
    want = expected_q.pop_front();
    compare_field("ok", 32'(want.ok), 32'(got.ok));
    compare_field("read_data", want.read_data, got.read_data);
    compare_field("read_stamp", want.read_stamp, got.read_stamp);
    compare_field("skip_total", want.skip_total, got.skip_total);
    compare_field("fill_count", 32'(want.fill_count), 32'(got.fill_count));
  endfunction
endclass

module testbench;
  import tfrb_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned DrainWait  = DefaultDepth + 12;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      push;
  logic      full;
  in_word_t  in_word;
  logic      empty;
  logic      pop;
  out_word_t res_word;

  frame_ring_checker ring_sb;
  int unsigned       send_idle_pct;
  int unsigned       recv_idle_pct;
  int unsigned       stall_cycles;
  logic [31:0]       stamp_base;

  timestamped_frame_ring_buffer_unit u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push       (push),
    .full       (full),
    .in_word_i  (in_word),
    .empty      (empty),
    .pop        (pop),
    .res_word_o (res_word)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    pop <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) ring_sb.note_word(in_word);
      if (pop && !empty) ring_sb.check_word(res_word);
      if ((push && !full) || (pop && !empty)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= StallLimit) begin
          $display("%0t: no word moved for %0d cycles", $time, StallLimit);
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  function automatic in_word_t make_word(logic op, logic [31:0] stamp, logic [31:0] payload);
    in_word_t w;
    w.op      = op;
    w.stamp   = stamp;
    w.payload = payload;
    return w;
  endfunction

  // mostly rising stamps, kept at or above the last stamp handed out
  function automatic logic [31:0] next_stamp();
    logic [32:0] sum;
    if (stamp_base < ring_sb.last_stamp) stamp_base = ring_sb.last_stamp;
    sum = {1'b0, stamp_base} + 33'($urandom_range(0, 3));
    if ($urandom_range(0, 24) == 0) sum = sum + 33'($urandom_range(0, 32'h000F_FFFF));
    stamp_base = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    return stamp_base;
  endfunction

  function automatic in_word_t random_word(int unsigned add_pct);
    in_word_t    w;
    int unsigned pick;
    w.op      = OP_GET;
    w.stamp   = $urandom();
    w.payload = $urandom();
    if ($urandom_range(0, 99) < add_pct) begin
      w.op = OP_ADD;
      pick = $urandom_range(0, 199);
      if (pick == 0) begin
        w.stamp = $urandom();
      end else if (pick < 16) begin
        w.stamp = $urandom_range(0, stamp_base);
      end else begin
        w.stamp = next_stamp();
      end
    end
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (full);
  endtask

  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (ring_sb.pending() != 0);
  endtask

  task automatic send_random(int unsigned count);
    int unsigned add_pct;
    add_pct = 55;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 40 == 0) add_pct = $urandom_range(25, 80);
      send_word(random_word(add_pct));
    end
  endtask

  initial begin
    push       <= 1'b0;
    pop        <= 1'b0;
    in_word    <= '0;
    rst_n      <= 1'b0;
    ring_sb       = new();
    stall_cycles  = 0;
    stamp_base    = 32'd100;
    send_idle_pct = 37;
    recv_idle_pct = 82;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty ring, tied stamps, drain to empty
    send_word(make_word(OP_GET, 32'h0, 32'h0));
    send_word(make_word(OP_ADD, 32'h0, 32'h0));
    send_word(make_word(OP_ADD, 32'h0, 32'hFFFF_FFFF));
    send_word(make_word(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_word(make_word(OP_GET, 32'h0, 32'h0));
    send_word(make_word(OP_GET, 32'h0, 32'h0));
    // fill the ring, then overwrite unread slots with redirect and ties
    send_word(make_word(OP_ADD, 32'd20, 32'h1111_0001));
    send_word(make_word(OP_ADD, 32'd40, 32'h1111_0002));
    send_word(make_word(OP_ADD, 32'd40, 32'h1111_0003));
    send_word(make_word(OP_ADD, 32'd10, 32'h1111_0004));
    send_word(make_word(OP_ADD, 32'd30, 32'h1111_0005));
    send_word(make_word(OP_ADD, 32'd40, 32'h1111_0006));
    send_word(make_word(OP_ADD, 32'd5,  32'h1111_0007));
    send_word(make_word(OP_ADD, 32'd15, 32'h1111_0008));
    send_word(make_word(OP_ADD, 32'd25, 32'h2222_0001));
    send_word(make_word(OP_ADD, 32'd26, 32'h2222_0002));
    send_word(make_word(OP_ADD, 32'd40, 32'h2222_0003));
    // gets until only stale slots are left
    for (int i = 0; i < 8; i++) send_word(make_word(OP_GET, 32'h0, 32'h0));
    drain();

    send_random(560);
    drain();

    send_idle_pct = 82;
    recv_idle_pct = 37;
    send_random(580);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(590);
    // largest stamp last: once it is returned no older word can follow
    send_word(make_word(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_word(make_word(OP_GET, 32'h0, 32'h0));
    send_word(make_word(OP_ADD, 32'h0, 32'h0));
    send_word(make_word(OP_GET, 32'h0, 32'h0));
    send_word(make_word(OP_GET, 32'h0, 32'h0));
    drain();
    repeat (DrainWait) @(posedge clk);

    if (ring_sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
